>>> sv/spd_pkg.sv
// shared types, constants and crc function for the servo packet deframer
`default_nettype none

package spd_pkg;

  // default largest payload in bytes (instruction plus parameters)
  localparam int MAX_PAYLOAD_DEF = 1024;

  // crc-16 generator polynomial, msb first
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // header and id codes
  localparam logic [7:0] HDR_FF   = 8'hFF;
  localparam logic [7:0] HDR_FD   = 8'hFD;
  localparam logic [7:0] HDR_RSV  = 8'h00;
  localparam logic [7:0] ID_MAX   = 8'd252;
  localparam logic [7:0] ID_BCAST = 8'hFE;

  // register map
  localparam logic CFG_IDX_DEVICE_ID = 1'b0;
  localparam logic [7:0] DEVICE_ID_RST = 8'd1;

  // parser states
  typedef enum logic [3:0] {
    ST_HDR1    = 4'd0,
    ST_HDR2    = 4'd1,
    ST_HDR3    = 4'd2,
    ST_RSV     = 4'd3,
    ST_ID      = 4'd4,
    ST_LEN_LO  = 4'd5,
    ST_LEN_HI  = 4'd6,
    ST_PAYLOAD = 4'd7,
    ST_CRC_LO  = 4'd8,
    ST_CRC_HI  = 4'd9
  } parse_state_e;

  // result word kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_GOOD_ME    = 2'd1,
    KIND_GOOD_OTHER = 2'd2,
    KIND_CRC_ERR    = 2'd3
  } kind_e;

  // one result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  packet_id;
    logic [7:0]  crc_fail_count;
    logic        end_of_packet;
  } result_t;

  // one byte through the crc, msb first, eight shift steps
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // crc over the canonical header ff ff fd 00 from a zero seed
  localparam logic [15:0] CRC_HDR =
    crc16_feed(crc16_feed(crc16_feed(crc16_feed(16'h0000, HDR_FF), HDR_FF), HDR_FD), HDR_RSV);

endpackage

`default_nettype wire

>>> sv/spd_crc_byte.sv
// one-byte crc-16 update step
`default_nettype none

module spd_crc_byte
  import spd_pkg::*;
(
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  // table-free byte step, eight xor stages on a 16-bit value
  always_comb begin
    crc_o = crc16_feed(crc_i, byte_i);
  end

endmodule

`default_nettype wire

>>> sv/spd_parser.sv
// header hunt, length check, payload pass-through and crc verdict
`default_nettype none

module spd_parser
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] device_id_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam int RemW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  parse_state_e state_q, state_d;
  logic [15:0]     crc_q, crc_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [7:0]      pkt_id_q, pkt_id_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [9:0]      pos_q, pos_d;
  logic [7:0]      fail_q, fail_d;

  logic [15:0] crc_next;
  logic [15:0] len;
  logic [15:0] len_pay;
  logic        len_ok;
  logic [15:0] rx_crc;

  // crc of the current byte over the running value
  spd_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign len     = {byte_i, len_lo_q};
  assign len_pay = len - 16'd2;
  assign len_ok  = (len >= 16'd2) && (len_pay <= MaxLen);
  assign rx_crc  = {byte_i, crc_lo_q};

  // next state and result word
  always_comb begin
    state_d  = state_q;
    crc_d    = crc_q;
    rem_d    = rem_q;
    len_lo_d = len_lo_q;
    pkt_id_d = pkt_id_q;
    crc_lo_d = crc_lo_q;
    pos_d    = pos_q;
    fail_d   = fail_q;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.payload_byte   = 8'h00;
    res_o.payload_index  = 10'd0;
    res_o.packet_id      = pkt_id_q;
    res_o.crc_fail_count = fail_q;
    res_o.end_of_packet  = 1'b0;

    case (state_q)
      ST_HDR1: begin
        if (byte_i == HDR_FF) state_d = ST_HDR2;
      end
      ST_HDR2: begin
        if (byte_i == HDR_FF) begin
          state_d = ST_HDR3;
        end else if (byte_i == HDR_FD) begin
          state_d = ST_RSV;
        end else begin
          state_d = ST_HDR1;
        end
      end
      ST_HDR3: begin
        state_d = (byte_i == HDR_FD) ? ST_RSV : ST_HDR1;
      end
      ST_RSV: begin
        if (byte_i == HDR_RSV) begin
          crc_d   = CRC_HDR;
          state_d = ST_ID;
        end else begin
          state_d = ST_HDR1;
        end
      end
      ST_ID: begin
        if (byte_i <= ID_MAX || byte_i == ID_BCAST) begin
          pkt_id_d = byte_i;
          crc_d    = crc_next;
          state_d  = ST_LEN_LO;
        end else begin
          state_d = ST_HDR1;
        end
      end
      ST_LEN_LO: begin
        len_lo_d = byte_i;
        crc_d    = crc_next;
        state_d  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        crc_d = crc_next;
        if (!len_ok) begin
          state_d = ST_HDR1;
        end else begin
          rem_d   = RemW'(len_pay);
          pos_d   = 10'd0;
          state_d = (len_pay != 16'd0) ? ST_PAYLOAD : ST_CRC_LO;
        end
      end
      ST_PAYLOAD: begin
        crc_d               = crc_next;
        res_valid_o         = 1'b1;
        res_o.payload_byte  = byte_i;
        res_o.payload_index = pos_q;
        pos_d               = pos_q + 10'd1;
        rem_d               = rem_q - RemW'(1);
        if (rem_q == RemW'(1)) state_d = ST_CRC_LO;
      end
      ST_CRC_LO: begin
        crc_lo_d = byte_i;
        state_d  = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        res_valid_o         = 1'b1;
        res_o.end_of_packet = 1'b1;
        if (rx_crc == crc_q) begin
          res_o.kind = (pkt_id_q == device_id_i || pkt_id_q == ID_BCAST) ?
                       KIND_GOOD_ME : KIND_GOOD_OTHER;
        end else begin
          fail_d               = fail_q + 8'd1;
          res_o.kind           = KIND_CRC_ERR;
          res_o.crc_fail_count = fail_q + 8'd1;
        end
        state_d = ST_HDR1;
        crc_d   = 16'h0000;
      end
      default: begin
        state_d = ST_HDR1;
      end
    endcase
  end

  // parser state, updated once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HDR1;
      crc_q    <= 16'h0000;
      rem_q    <= '0;
      len_lo_q <= 8'h00;
      pkt_id_q <= 8'h00;
      crc_lo_q <= 8'h00;
      pos_q    <= 10'd0;
      fail_q   <= 8'h00;
    end else if (step_i) begin
      state_q  <= state_d;
      crc_q    <= crc_d;
      rem_q    <= rem_d;
      len_lo_q <= len_lo_d;
      pkt_id_q <= pkt_id_d;
      crc_lo_q <= crc_lo_d;
      pos_q    <= pos_d;
      fail_q   <= fail_d;
    end
  end

  // results only come from payload bytes and the second crc byte
  a_res_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q == ST_PAYLOAD || state_q == ST_CRC_HI))
    else $error("result outside payload or verdict state");

  // payload state always has bytes left to take
  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAYLOAD |-> rem_q != '0)
    else $error("payload state with nothing remaining");

  // verdict returns to the hunt
  a_verdict_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && state_q == ST_CRC_HI) |=> state_q == ST_HDR1)
    else $error("no return to header hunt after verdict");

  // fail counter moves only on a verdict
  a_fail_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && state_q == ST_CRC_HI) |=> $stable(fail_q))
    else $error("fail counter moved outside a verdict");

endmodule

`default_nettype wire

>>> sv/servo_packet_deframer_crc16.sv
// top level: apb register, input byte register, parser and output word register
//
// Servo bus packet deframer. Takes one received serial byte per cycle on the
// slave stream, hunts for the header FF FF FD 00 (or FF FD 00), checks the ID
// and length, passes each payload byte on as a word with tuser 0, and after the
// two CRC bytes emits one verdict word with tlast high: tuser 1 good and for
// this device (own ID or broadcast FE), 2 good but for another ID, 3 CRC error.
// The block sustains one byte per cycle while the output is not stalled; a
// result word passes from the input byte register through the single parser
// step into the output word register. While a result word waits on a stalled
// receiver, the held byte cannot move, so the input stalls too, even for bytes
// that make no word.
// device_id sits at byte address 0 of the APB port and resets to 1.
`default_nettype none

module servo_packet_deframer_crc16
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // received bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] payload_byte, [17:8] payload_index, [25:18] packet_id,
  // [33:26] crc_fail_count, [39:34] zero
  output logic      [39:0] m_axis_tdata,
  output logic      [1:0]  m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // end_of_packet
);

  logic [7:0] device_id_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_DEVICE_ID);
  assign prdata = (paddr[2] == CFG_IDX_DEVICE_ID) ? {24'h000000, device_id_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DEVICE_ID_RST;
    end else if (cfg_wr) begin
      device_id_q <= pwdata[7:0];
    end
  end

  // pipeline control: the held byte moves when the output register has room
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // input byte register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  spd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (in_byte_q),
    .device_id_i (device_id_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_q.crc_fail_count, out_q.packet_id,
                          out_q.payload_index, out_q.payload_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.end_of_packet;

endmodule

`default_nettype wire
